@@ design/ncdc_pkg.sv @@
// shared widths, turn constants, arctangent table and stage struct
package ncdc_pkg;

  localparam int CW       = 22;
  localparam int SW       = 26;
  localparam int NW       = 32;
  localparam int CRW      = 62;
  localparam int AW       = 32;
  localparam int INT_FRAC = 16;
  localparam int PRE_SH   = 24;

  localparam logic [AW-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [AW-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [AW-1:0] ATAN_TURN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [NW-1:0] nr;
    logic signed [NW-1:0] ni;
    logic signed [NW-1:0] dr;
    logic signed [NW-1:0] di;
  } nd_t;

endpackage

@@ design/ncdc_front.sv @@
// pixel to complex point mapping and numerator / denominator polynomial pipeline
module ncdc_front #(
  parameter int PIXEL_BITS = 10,
  parameter int FRAC_BITS  = 28
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [PIXEL_BITS-1:0] column_i,
  input  logic [PIXEL_BITS-1:0] row_i,
  input  logic [31:0]           real_start_i,
  input  logic [31:0]           imag_start_i,
  input  logic [31:0]           real_step_i,
  input  logic [31:0]           imag_step_i,
  output logic                  vld_o,
  output ncdc_pkg::nd_t         nd_o
);

  localparam int PW   = PIXEL_BITS + 33;
  localparam int SUMW = PW + 1;
  localparam int SH   = FRAC_BITS - ncdc_pkg::INT_FRAC;
  localparam int CW   = ncdc_pkg::CW;
  localparam int SW   = ncdc_pkg::SW;
  localparam int NW   = ncdc_pkg::NW;
  localparam int FB   = ncdc_pkg::INT_FRAC;
  localparam logic signed [31:0] LIM  = 32'sd1048576;
  localparam logic signed [31:0] NLIM = -32'sd1048576;
  localparam logic signed [NW-1:0] ONE = 32'sd65536;

  function automatic logic signed [CW-1:0] to_int(input logic signed [SUMW-1:0] s);
    logic signed [31:0] sat;
    logic signed [31:0] shf;
    logic signed [CW-1:0] res;
    if (s[SUMW-1:31] == {(SUMW-31){s[SUMW-1]}}) begin
      sat = s[31:0];
    end else if (s[SUMW-1]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7FFF_FFFF;
    end
    shf = sat >>> SH;
    if (shf > LIM) begin
      res = LIM[CW-1:0];
    end else if (shf < NLIM) begin
      res = NLIM[CW-1:0];
    end else begin
      res = shf[CW-1:0];
    end
    return res;
  endfunction

  logic [4:0] vld_q;

  logic signed [PW-1:0] pre_d, pim_d, pre_q, pim_q;
  logic signed [CW-1:0] re_b_d, im_b_d, re_b_q, im_b_q;
  logic signed [CW-1:0] re_c_q, im_c_q;
  logic signed [SW-1:0] x2_d, y2_d, xy_d, x2_q, y2_q, xy_q;
  logic signed [NW-1:0] x3_d, ry2_d, x2i_d, y2i_d, dr_d, di_d;
  logic signed [NW-1:0] x3_q, ry2_q, x2i_q, y2i_q, dr_q, di_q;
  ncdc_pkg::nd_t        nd_d, nd_q;

  // stage a: column and row products
  always_comb begin
    logic signed [PW-1:0] col_w, row_w, rstep_w, istep_w;
    col_w   = {{(PW-PIXEL_BITS){1'b0}}, column_i};
    row_w   = {{(PW-PIXEL_BITS){1'b0}}, row_i};
    rstep_w = {{(PW-32){real_step_i[31]}}, real_step_i};
    istep_w = {{(PW-32){imag_step_i[31]}}, imag_step_i};
    pre_d   = col_w * rstep_w;
    pim_d   = row_w * istep_w;
  end

  // stage b: offset, saturate, rescale
  always_comb begin
    logic signed [SUMW-1:0] sre, sim;
    sre = {{(SUMW-32){real_start_i[31]}}, real_start_i} + {pre_q[PW-1], pre_q};
    sim = {{(SUMW-32){imag_start_i[31]}}, imag_start_i} - {pim_q[PW-1], pim_q};
    re_b_d = to_int(sre);
    im_b_d = to_int(sim);
  end

  // stage c: squares and cross product
  always_comb begin
    logic signed [2*CW-1:0] pxx, pyy, pxy;
    pxx  = (2*CW)'(re_b_q) * (2*CW)'(re_b_q);
    pyy  = (2*CW)'(im_b_q) * (2*CW)'(im_b_q);
    pxy  = (2*CW)'(re_b_q) * (2*CW)'(im_b_q);
    x2_d = pxx[SW+FB-1:FB];
    y2_d = pyy[SW+FB-1:FB];
    xy_d = pxy[SW+FB-1:FB];
  end

  // stage d: cubic terms and denominator
  always_comb begin
    logic signed [SW+CW-1:0] p1, p2, p3, p4;
    logic signed [NW-1:0] x2w, y2w, xyw, dd;
    p1    = (SW+CW)'(x2_q) * (SW+CW)'(re_c_q);
    p2    = (SW+CW)'(y2_q) * (SW+CW)'(re_c_q);
    p3    = (SW+CW)'(x2_q) * (SW+CW)'(im_c_q);
    p4    = (SW+CW)'(y2_q) * (SW+CW)'(im_c_q);
    x3_d  = p1[NW+FB-1:FB];
    ry2_d = p2[NW+FB-1:FB];
    x2i_d = p3[NW+FB-1:FB];
    y2i_d = p4[NW+FB-1:FB];
    x2w   = {{(NW-SW){x2_q[SW-1]}}, x2_q};
    y2w   = {{(NW-SW){y2_q[SW-1]}}, y2_q};
    xyw   = {{(NW-SW){xy_q[SW-1]}}, xy_q};
    dd    = x2w - y2w;
    dr_d  = dd + (dd <<< 1);
    di_d  = (xyw <<< 2) + (xyw <<< 1);
  end

  // stage e: numerator
  always_comb begin
    nd_d.nr = x3_q - ry2_q - (ry2_q <<< 1) - ONE;
    nd_d.ni = x2i_q + (x2i_q <<< 1) - y2i_q;
    nd_d.dr = dr_q;
    nd_d.di = di_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q  <= pre_d;
      pim_q  <= pim_d;
      re_b_q <= re_b_d;
      im_b_q <= im_b_d;
      x2_q   <= x2_d;
      y2_q   <= y2_d;
      xy_q   <= xy_d;
      re_c_q <= re_b_q;
      im_c_q <= im_b_q;
      x3_q   <= x3_d;
      ry2_q  <= ry2_d;
      x2i_q  <= x2i_d;
      y2i_q  <= y2i_d;
      dr_q   <= dr_d;
      di_q   <= di_d;
      nd_q   <= nd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  assign vld_o = vld_q[4];
  assign nd_o  = nd_q;

endmodule

@@ design/ncdc_cordic.sv @@
// pipelined vectoring cordic with angle in binary turns and sideband
module ncdc_cordic #(
  parameter int STAGES = 20,
  parameter int SIDE_W = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic [SIDE_W-1:0]               side_i,
  input  logic signed [ncdc_pkg::CRW-1:0] x_i,
  input  logic signed [ncdc_pkg::CRW-1:0] y_i,
  output logic                            vld_o,
  output logic [SIDE_W-1:0]               side_o,
  output logic [ncdc_pkg::AW-1:0]         ang_o,
  output logic signed [ncdc_pkg::CRW-1:0] mag_o
);

  localparam int CRW = ncdc_pkg::CRW;
  localparam int AW  = ncdc_pkg::AW;

  logic signed [CRW-1:0] x_q [STAGES+1];
  logic signed [CRW-1:0] y_q [STAGES+1];
  logic [AW-1:0]         a_q [STAGES+1];
  logic [SIDE_W-1:0]     s_q [STAGES+1];
  logic [STAGES:0]       v_q;

  // fold the left half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        a_q[0] <= ncdc_pkg::HALF_TURN;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        a_q[0] <= '0;
      end
      s_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[k][CRW-1]) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          a_q[k+1] <= a_q[k] + ncdc_pkg::ATAN_TURN[k];
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          a_q[k+1] <= a_q[k] - ncdc_pkg::ATAN_TURN[k];
        end
        s_q[k+1] <= s_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-1:0], vld_i};
    end
  end

  assign vld_o  = v_q[STAGES];
  assign side_o = s_q[STAGES];
  assign ang_o  = a_q[STAGES];
  assign mag_o  = x_q[STAGES];

endmodule

@@ design/ncdc_color.sv @@
// argument to rainbow mapping and intensity scaling with output register
module ncdc_color (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [ncdc_pkg::AW-1:0] ang_i,
  input  logic [ncdc_pkg::AW-1:0] arg_i,
  input  logic                    nzero_i,
  input  logic                    dzero_i,
  output logic                    vld_o,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o
);

  localparam int AW = ncdc_pkg::AW;

  logic [2:0]  vld_q;
  logic [30:0] t_d, t_h_q, t_i_q;
  logic [9:0]  vi_d, vi_q;
  logic        frac_d, frac_q;
  logic [7:0]  r_d, g_d, b_d, r_q, g_q, b_q;
  logic [7:0]  ro_d, go_d, bo_d, ro_q, go_q, bo_q;

  // intensity clamp and argument to 0..1023
  always_comb begin
    logic [AW-1:0] arg;
    logic [AW:0]   u;
    logic [AW+10:0] vq;
    if (nzero_i) begin
      t_d = '0;
    end else if (dzero_i) begin
      t_d = 31'(ncdc_pkg::QUARTER_TURN);
    end else if (ang_i > ncdc_pkg::HALF_TURN) begin
      t_d = '0;
    end else if (ang_i > ncdc_pkg::QUARTER_TURN) begin
      t_d = 31'(ncdc_pkg::QUARTER_TURN);
    end else begin
      t_d = ang_i[30:0];
    end
    arg = (nzero_i || dzero_i) ? '0 : arg_i;
    if (arg <= ncdc_pkg::HALF_TURN) begin
      u = {1'b0, arg} + {1'b0, ncdc_pkg::HALF_TURN};
    end else begin
      u = {1'b0, arg} - {1'b0, ncdc_pkg::HALF_TURN};
    end
    vq     = {u, 10'b0} - {10'b0, u};
    vi_d   = vq[AW+9:AW];
    frac_d = |vq[AW-1:0];
  end

  // four segment rainbow
  always_comb begin
    logic [9:0] dn;
    r_d = '0;
    g_d = '0;
    b_d = '0;
    dn  = '0;
    unique case (vi_q[9:8])
      2'd0: begin
        g_d = vi_q[7:0];
        b_d = 8'd255;
      end
      2'd1: begin
        dn  = 10'd512 - vi_q - {9'b0, frac_q};
        g_d = 8'd255;
        b_d = dn[8] ? 8'd255 : dn[7:0];
      end
      2'd2: begin
        r_d = vi_q[7:0];
        g_d = 8'd255;
      end
      2'd3: begin
        dn  = 10'd0 - vi_q - {9'b0, frac_q};
        r_d = 8'd255;
        g_d = (dn == 10'd256) ? 8'd255 : dn[7:0];
      end
      default: begin
        r_d = '0;
      end
    endcase
  end

  // channel times intensity, truncated
  always_comb begin
    logic [38:0] pr, pg, pb;
    pr   = 39'(t_i_q) * 39'(r_q);
    pg   = 39'(t_i_q) * 39'(g_q);
    pb   = 39'(t_i_q) * 39'(b_q);
    ro_d = pr[37:30];
    go_d = pg[37:30];
    bo_d = pb[37:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_h_q  <= t_d;
      vi_q   <= vi_d;
      frac_q <= frac_d;
      t_i_q  <= t_h_q;
      r_q    <= r_d;
      g_q    <= g_d;
      b_q    <= b_d;
      ro_q   <= ro_d;
      go_q   <= go_d;
      bo_q   <= bo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  assign vld_o   = vld_q[2];
  assign red_o   = ro_q;
  assign green_o = go_q;
  assign blue_o  = bo_q;

endmodule

@@ design/newton_cubic_domain_color_pixel.sv @@
// domain coloring pixel for (z^3-1)/(3z^2): config port, pipeline and stream glue
// path: polynomial front end, numerator and denominator cordics, difference register, intensity cordic, color
// throughput: one pixel per cycle; the whole pipeline advances unless the output beat is held
// a held output beat stalls every stage; no beat is dropped or repeated
// reset: asynchronous active low, clears all valid bits and loads the default window
module newton_cubic_domain_color_pixel #(
  parameter int PIXEL_BITS    = 10,
  parameter int FRAC_BITS     = 28,
  parameter int CORDIC_STAGES = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // column, row
  input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // red, green, blue
  output logic [23:0]                         m_axis_tdata
);

  localparam int STG  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int CRW  = ncdc_pkg::CRW;
  localparam int NW   = ncdc_pkg::NW;
  localparam int AW   = ncdc_pkg::AW;
  localparam int PSH  = ncdc_pkg::PRE_SH;

  typedef enum logic [1:0] {
    REG_REAL_START = 2'd0,
    REG_IMAG_START = 2'd1,
    REG_REAL_STEP  = 2'd2,
    REG_IMAG_STEP  = 2'd3
  } reg_e;

  logic [31:0] real_start_q, imag_start_q, real_step_q, imag_step_q;
  reg_e        wsel;
  logic        en;

  // configuration registers
  assign wsel   = reg_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_start_q <= 32'hE000_0000;
      imag_start_q <= 32'h2000_0000;
      real_step_q  <= 32'd1049601;
      imag_step_q  <= 32'd1049601;
    end else if (psel && penable && pwrite && pready) begin
      unique case (wsel)
        REG_REAL_START: real_start_q <= pwdata;
        REG_IMAG_START: imag_start_q <= pwdata;
        REG_REAL_STEP:  real_step_q  <= pwdata;
        REG_IMAG_STEP:  imag_step_q  <= pwdata;
        default:        real_start_q <= real_start_q;
      endcase
    end
  end

  always_comb begin
    unique case (wsel)
      REG_REAL_START: prdata = real_start_q;
      REG_IMAG_START: prdata = imag_start_q;
      REG_REAL_STEP:  prdata = real_step_q;
      REG_IMAG_STEP:  prdata = imag_step_q;
      default:        prdata = '0;
    endcase
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // polynomial front end
  logic          f_vld;
  ncdc_pkg::nd_t f_nd;

  ncdc_front #(
    .PIXEL_BITS(PIXEL_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .vld_i       (s_axis_tvalid),
    .column_i    (s_axis_tdata[PIXEL_BITS-1:0]),
    .row_i       (s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
    .real_start_i(real_start_q),
    .imag_start_i(imag_start_q),
    .real_step_i (real_step_q),
    .imag_step_i (imag_step_q),
    .vld_o       (f_vld),
    .nd_o        (f_nd)
  );

  logic                  nzero, dzero;
  logic signed [CRW-1:0] xn, yn, xd, yd;

  assign nzero = (f_nd.nr == '0) && (f_nd.ni == '0);
  assign dzero = (f_nd.dr == '0) && (f_nd.di == '0);
  assign xn = {{(CRW-NW-PSH){f_nd.nr[NW-1]}}, f_nd.nr, {PSH{1'b0}}};
  assign yn = {{(CRW-NW-PSH){f_nd.ni[NW-1]}}, f_nd.ni, {PSH{1'b0}}};
  assign xd = {{(CRW-NW-PSH){f_nd.dr[NW-1]}}, f_nd.dr, {PSH{1'b0}}};
  assign yd = {{(CRW-NW-PSH){f_nd.di[NW-1]}}, f_nd.di, {PSH{1'b0}}};

  // numerator and denominator angles side by side
  logic                  cn_vld;
  logic [1:0]            cn_side;
  logic [AW-1:0]         an, ad;
  logic signed [CRW-1:0] mn, md;

  ncdc_cordic #(
    .STAGES(STG),
    .SIDE_W(2)
  ) u_cordic_num (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (f_vld),
    .side_i({nzero, dzero}),
    .x_i   (xn),
    .y_i   (yn),
    .vld_o (cn_vld),
    .side_o(cn_side),
    .ang_o (an),
    .mag_o (mn)
  );

  ncdc_cordic #(
    .STAGES(STG),
    .SIDE_W(1)
  ) u_cordic_den (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (f_vld),
    .side_i(1'b0),
    .x_i   (xd),
    .y_i   (yd),
    .vld_o (),
    .side_o(),
    .ang_o (ad),
    .mag_o (md)
  );

  // argument difference and intensity vector (|D|, 5|N|)
  logic                  g_vld_q;
  logic [AW-1:0]         g_arg_q;
  logic [1:0]            g_side_q;
  logic signed [CRW-1:0] g_x_q, g_y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_arg_q  <= an - ad;
      g_side_q <= cn_side;
      g_x_q    <= md;
      g_y_q    <= (mn <<< 2) + mn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= cn_vld;
    end
  end

  logic                  ct_vld;
  logic [AW+1:0]         ct_side;
  logic [AW-1:0]         ang_t;

  ncdc_cordic #(
    .STAGES(STG),
    .SIDE_W(AW+2)
  ) u_cordic_int (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (g_vld_q),
    .side_i({g_arg_q, g_side_q}),
    .x_i   (g_x_q),
    .y_i   (g_y_q),
    .vld_o (ct_vld),
    .side_o(ct_side),
    .ang_o (ang_t),
    .mag_o ()
  );

  logic [7:0] red, green, blue;

  ncdc_color u_color (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (ct_vld),
    .ang_i  (ang_t),
    .arg_i  (ct_side[AW+1:2]),
    .nzero_i(ct_side[1]),
    .dzero_i(ct_side[0]),
    .vld_o  (m_axis_tvalid),
    .red_o  (red),
    .green_o(green),
    .blue_o (blue)
  );

  assign m_axis_tdata = {blue, green, red};

endmodule

@@ design/ncdc_checker.sv @@
// port level checks on the pixel pipeline, bound to the top level
module ncdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // held output beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // empty output slot never blocks input
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with free output slot");

  // input only stalls behind a held output beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back pressure");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !$past(rst_ni) && rst_ni |-> !m_axis_tvalid)
    else $error("output beat right after reset");

endmodule

bind newton_cubic_domain_color_pixel ncdc_checker u_ncdc_checker (.*);
